// ===== rtl/core/dbl_pkg.sv =====
// Shared types, constants and helpers for the debounced single-button lock.
// Used by dbl_eval, debounce_single_button_lock and dbl_checker.
package dbl_pkg;

  localparam int NUM_SWITCHES_DEF = 4;
  localparam int NUM_SWITCHES_MAX = 8;
  localparam int IDX_MAX_W        = 3;

  localparam int              CNT_W   = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 16'd50;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_DEBOUNCE_TICKS = '0;

  typedef struct packed {
    logic                 press_valid;
    logic [IDX_MAX_W-1:0] press_switch;
    logic                 release_valid;
    logic [IDX_MAX_W-1:0] release_switch;
  } evt_t;

  // Evaluation order of the switches: 0, 2, 3, ..., n-1, then 1.
  function automatic int order_at(input int k, input int n);
    int s;
    if (k == 0) begin
      s = 0;
    end else if (k == n - 1) begin
      s = 1;
    end else begin
      s = k + 1;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/dbl_eval.sv =====
// Per-tick evaluation: stable-time counters, debounced levels and the
// single-active lock. Purely combinational; depends on dbl_pkg.
module dbl_eval #(
  parameter int NUM_SWITCHES = dbl_pkg::NUM_SWITCHES_DEF
) (
  input  logic [NUM_SWITCHES-1:0]    raw,
  input  logic [NUM_SWITCHES-1:0]    prev_raw,
  input  logic [NUM_SWITCHES-1:0]    stable,
  input  logic [NUM_SWITCHES-1:0]    active,
  input  logic [dbl_pkg::CNT_W-1:0]  debounce_ticks,
  input  logic [dbl_pkg::CNT_W-1:0]  cnt     [NUM_SWITCHES],
  output logic [dbl_pkg::CNT_W-1:0]  cnt_nxt [NUM_SWITCHES],
  output logic [NUM_SWITCHES-1:0]    stable_nxt,
  output logic [NUM_SWITCHES-1:0]    active_nxt,
  output dbl_pkg::evt_t              evt
);

  logic [NUM_SWITCHES-1:0] accept;

  always_comb begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      if (raw[i] != prev_raw[i]) begin
        cnt_nxt[i] = '0;
      end else if (cnt[i] == dbl_pkg::CNT_MAX) begin
        cnt_nxt[i] = cnt[i];
      end else begin
        cnt_nxt[i] = cnt[i] + 1'b1;
      end
      accept[i] = (cnt_nxt[i] > debounce_ticks) && (raw[i] != stable[i]);
    end
  end

  always_comb begin
    int                      s;
    logic [NUM_SWITCHES-1:0] others;
    stable_nxt = stable;
    active_nxt = active;
    evt        = '0;
    for (int k = 0; k < NUM_SWITCHES; k++) begin
      s         = dbl_pkg::order_at(k, NUM_SWITCHES);
      others    = active_nxt;
      others[s] = 1'b0;
      if (accept[s]) begin
        stable_nxt[s] = raw[s];
        if (!raw[s]) begin
          if (others == '0) begin
            active_nxt[s]    = 1'b1;
            evt.press_valid  = 1'b1;
            evt.press_switch = dbl_pkg::IDX_MAX_W'(s);
          end
        end else if (active_nxt[s]) begin
          active_nxt[s]      = 1'b0;
          evt.release_valid  = 1'b1;
          evt.release_switch = dbl_pkg::IDX_MAX_W'(s);
        end
      end
    end
  end

endmodule

// ===== rtl/core/debounce_single_button_lock.sv =====
// Top level of the debounced single-button lock with its APB-style register.
// Depends on dbl_pkg and dbl_eval.
//
// Each input transaction on in_* is one sample tick carrying the raw
// active-low switch levels, one bit per switch. Each tick gives exactly one
// output transaction on out_* with the press event, the release event and the
// mask of the switch that is active after the tick.
// A level is accepted once it has been steady for more than debounce_ticks
// ticks; a press takes the lock only when no other switch holds it, and a
// release of the holder reports a release event.
// An input transaction passes through one input register and then one result
// register to out_tvalid. A new tick is taken every cycle unless the receiver stalls.
// When the receiver stalls, the result register holds its transaction and
// in_tready drops in the same cycle, so the input register holds as well.
// Reset clears both stages, marks every switch released with saturated
// counters and no active switch, and sets debounce_ticks to 50.
// The register debounce_ticks lies at byte address 0; the user must write it only
// while no transaction is in flight, as the block itself does not enforce this.
module debounce_single_button_lock #(
  parameter int NUM_SWITCHES = dbl_pkg::NUM_SWITCHES_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // in_tdata: raw_levels
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [((NUM_SWITCHES+7)/8)*8-1:0]          in_tdata,
  // out_tdata: press_valid, press_switch, release_valid, release_switch,
  // active_mask
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [((2+2*$clog2(NUM_SWITCHES)+NUM_SWITCHES+7)/8)*8-1:0] out_tdata,
  input  logic                                       cfg_psel,
  input  logic                                       cfg_penable,
  input  logic                                       cfg_pwrite,
  input  logic [dbl_pkg::CFG_ADDR_W-1:0]             cfg_paddr,
  input  logic [dbl_pkg::CFG_DATA_W-1:0]             cfg_pwdata,
  output logic [dbl_pkg::CFG_DATA_W-1:0]             cfg_prdata,
  output logic                                       cfg_pready
);

  localparam int IW    = $clog2(NUM_SWITCHES);
  localparam int RES_W = 2 + 2*IW + NUM_SWITCHES;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  logic                        en;
  logic                        s1_valid_r;
  logic [NUM_SWITCHES-1:0]     s1_raw_r;
  logic                        out_valid_r;
  logic [RES_W-1:0]            out_res_r;
  logic [RES_W-1:0]            out_res_nxt;

  logic [dbl_pkg::CNT_W-1:0]   debounce_ticks_r;
  logic [NUM_SWITCHES-1:0]     prev_raw_r;
  logic [NUM_SWITCHES-1:0]     stable_r;
  logic [NUM_SWITCHES-1:0]     active_r;
  logic [dbl_pkg::CNT_W-1:0]   cnt_r   [NUM_SWITCHES];
  logic [dbl_pkg::CNT_W-1:0]   cnt_nxt [NUM_SWITCHES];
  logic [NUM_SWITCHES-1:0]     stable_nxt;
  logic [NUM_SWITCHES-1:0]     active_nxt;
  dbl_pkg::evt_t               evt;
  logic                        cfg_hit;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_tvalid) begin
      s1_raw_r <= in_tdata[NUM_SWITCHES-1:0];
    end
  end

  dbl_eval #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_eval (
    .raw            (s1_raw_r),
    .prev_raw       (prev_raw_r),
    .stable         (stable_r),
    .active         (active_r),
    .debounce_ticks (debounce_ticks_r),
    .cnt            (cnt_r),
    .cnt_nxt        (cnt_nxt),
    .stable_nxt     (stable_nxt),
    .active_nxt     (active_nxt),
    .evt            (evt)
  );

  assign out_res_nxt = {active_nxt,
                        evt.release_switch[IW-1:0], evt.release_valid,
                        evt.press_switch[IW-1:0], evt.press_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r <= '1;
      stable_r   <= '1;
      active_r   <= '0;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        cnt_r[i] <= dbl_pkg::CNT_MAX;
      end
    end else if (en && s1_valid_r) begin
      prev_raw_r <= s1_raw_r;
      stable_r   <= stable_nxt;
      active_r   <= active_nxt;
      for (int i = 0; i < NUM_SWITCHES; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid_r) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_res_r);

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[dbl_pkg::CFG_ADDR_W-1:2] == dbl_pkg::REG_DEBOUNCE_TICKS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= dbl_pkg::DEBOUNCE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      debounce_ticks_r <= cfg_pwdata[dbl_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_hit) begin
      cfg_prdata = dbl_pkg::CFG_DATA_W'(debounce_ticks_r);
    end
  end

endmodule

// ===== rtl/core/dbl_checker.sv =====
// Port-level checks on the result channel of debounce_single_button_lock.
// Depends on dbl_pkg; attached to the top level by the bind at the end.
module dbl_sva #(
  parameter int NUM_SWITCHES = dbl_pkg::NUM_SWITCHES_DEF
) (
  input logic                                        clk,
  input logic                                        rst_n,
  input logic                                        out_tvalid,
  input logic                                        out_tready,
  input logic [((2+2*$clog2(NUM_SWITCHES)+NUM_SWITCHES+7)/8)*8-1:0] out_tdata
);

  localparam int IW = $clog2(NUM_SWITCHES);

  logic                    press_v;
  logic [IW-1:0]           press_s;
  logic                    rel_v;
  logic [IW-1:0]           rel_s;
  logic [NUM_SWITCHES-1:0] mask;

  assign press_v = out_tdata[0];
  assign press_s = out_tdata[IW:1];
  assign rel_v   = out_tdata[IW+1];
  assign rel_s   = out_tdata[2*IW+1:IW+2];
  assign mask    = out_tdata[2*IW+1+NUM_SWITCHES:2*IW+2];

  a_mask_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(mask))
    else $error("more than one switch is active");

  a_press_sets_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && press_v) |-> mask[press_s])
    else $error("pressed switch is not in the active mask");

  a_release_clears_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && rel_v) |-> (!mask[rel_s] && !(press_v && press_s == rel_s)))
    else $error("released switch is still active or pressed again");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((press_v || press_s == '0) && (rel_v || rel_s == '0)))
    else $error("switch index set without its event");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

endmodule

bind debounce_single_button_lock dbl_sva #(
  .NUM_SWITCHES (NUM_SWITCHES)
) u_dbl_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/dbl_checker.sv =====
// Scoreboard for the debounced single-button lock: watches the tick, result and
// register channels, predicts every result and compares it field by field.
// Depends on dbl_pkg for the register map and counter widths.
module dbl_checker
  import dbl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [15:0]           out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW_N = 4;
  localparam int SCAN_SEQ [0:SW_N-1] = '{0, 2, 3, 1};
  localparam logic [CFG_ADDR_W-1:0] DEBOUNCE_ADDR = {REG_DEBOUNCE_TICKS, 2'b00};

  typedef struct packed {
    logic            press_v;
    logic [1:0]      press_sw;
    logic            rel_v;
    logic [1:0]      rel_sw;
    logic [SW_N-1:0] mask;
  } tick_result_t;

  logic [CNT_W-1:0] hold_ticks;
  logic [SW_N-1:0]  last_raw;
  logic [SW_N-1:0]  settled;
  logic [SW_N-1:0]  holder;
  logic [CNT_W-1:0] steady [SW_N];
  tick_result_t     lock_results_q [$];
  tick_result_t     got;
  tick_result_t     want;
  int               errs;

  function automatic tick_result_t debounce_tick(input logic [SW_N-1:0] raw);
    tick_result_t r;
    int s;
    r = '0;
    for (int k = 0; k < SW_N; k++) begin
      s = SCAN_SEQ[k];
      if (raw[s] != last_raw[s]) begin
        steady[s] = '0;
      end else if (steady[s] != CNT_MAX) begin
        steady[s] = steady[s] + 1'b1;
      end
      if (steady[s] > hold_ticks && raw[s] != settled[s]) begin
        settled[s] = raw[s];
        if (!raw[s]) begin
          if ((holder & ~(SW_N'(1) << s)) == '0) begin
            holder[s] = 1'b1;
            r.press_v = 1'b1;
            r.press_sw = 2'(s);
          end
        end else if (holder[s]) begin
          holder[s] = 1'b0;
          r.rel_v = 1'b1;
          r.rel_sw = 2'(s);
        end
      end
      last_raw[s] = raw[s];
    end
    r.mask = holder;
    return r;
  endfunction

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks = DEBOUNCE_RESET;
      last_raw = '1;
      settled = '1;
      holder = '0;
      for (int i = 0; i < SW_N; i++) begin
        steady[i] = CNT_MAX;
      end
      lock_results_q.delete();
      errs = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == DEBOUNCE_ADDR) begin
        if (cfg_pwrite) begin
          hold_ticks = cfg_pwdata[CNT_W-1:0];
        end else begin
          check_field("debounce_ticks", hold_ticks, cfg_prdata[CNT_W-1:0]);
        end
      end
      if (in_tvalid && in_tready) begin
        lock_results_q.push_back(debounce_tick(in_tdata[SW_N-1:0]));
      end
      if (out_tvalid && out_tready) begin
        if (lock_results_q.size() == 0) begin
          $error("result transaction 0x%04h arrived with no tick pending", out_tdata);
          errs++;
        end else begin
          want = lock_results_q.pop_front();
          got.press_v = out_tdata[0];
          got.press_sw = out_tdata[2:1];
          got.rel_v = out_tdata[3];
          got.rel_sw = out_tdata[5:4];
          got.mask = out_tdata[9:6];
          check_field("press_valid", want.press_v, got.press_v);
          check_field("press_switch", want.press_sw, got.press_sw);
          check_field("release_valid", want.rel_v, got.rel_v);
          check_field("release_switch", want.rel_sw, got.rel_sw);
          check_field("active_mask", want.mask, got.mask);
        end
      end
    end
    mismatches <= errs;
    outstanding <= lock_results_q.size();
  end

endmodule

// ===== tb/debounce_single_button_lock_tb.sv =====
// Top of the testbench for debounce_single_button_lock: drives ticks, register
// accesses and result backpressure, and reports the verdict from dbl_checker.
// Depends on dbl_pkg, dbl_checker and the block itself.
module debounce_single_button_lock_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbl_pkg::*;

  localparam int SW_N = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [CFG_ADDR_W-1:0] DEBOUNCE_ADDR = {REG_DEBOUNCE_TICKS, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
  localparam logic [SW_N-1:0] ALL_RELEASED = 4'hF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int rx_wait = 0;
  int rx_draw = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  logic [SW_N-1:0] opening_seq [24] = '{
    4'hF, 4'hF, 4'hE, 4'hE, 4'hA, 4'hA, 4'hB, 4'hB, 4'hF, 4'hF, 4'hE, 4'hE,
    4'hB, 4'hB, 4'hF, 4'hF, 4'h5, 4'h5, 4'hF, 4'hF, 4'h0, 4'h0, 4'hF, 4'hF
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  debounce_single_button_lock #(
    .NUM_SWITCHES(SW_N)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  dbl_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else if (out_tvalid && out_tready) begin
      if (rx_burst) begin
        out_tready <= 1'b1;
      end else begin
        rx_draw = $urandom_range(0, 10);
        rx_wait <= rx_draw;
        out_tready <= (rx_draw == 0);
      end
    end else if (!out_tready) begin
      if (rx_wait <= 1) begin
        out_tready <= 1'b1;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("debounce_single_button_lock_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(input logic [SW_N-1:0] raw);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, raw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input bit write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CNT_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= addr;
    cfg_pwdata <= {16'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_debounce(input logic [CNT_W-1:0] ticks);
    cfg_access(1'b1, DEBOUNCE_ADDR, ticks);
    cfg_access(1'b0, DEBOUNCE_ADDR, '0);
  endtask

  function automatic logic [SW_N-1:0] pick_levels();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      return ALL_RELEASED;
    end else if (r < 7) begin
      return ~(SW_N'(1) << $urandom_range(0, SW_N - 1));
    end
    return SW_N'($urandom);
  endfunction

  // Mostly levels held long enough to settle, with glitches and short noise bursts.
  task automatic run_phase(input logic [CNT_W-1:0] ticks, input int n_items);
    int sent;
    int len;
    bit noise;
    logic [SW_N-1:0] lv;
    sent = 0;
    while (sent < n_items) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst <= ($urandom_range(0, 3) == 0);
      lv = pick_levels();
      noise = ($urandom_range(0, 4) == 0);
      len = noise ? $urandom_range(1, 3) : int'(ticks) + 1 + $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        if (noise) begin
          send_tick(SW_N'($urandom));
        end else if ($urandom_range(0, 19) == 0) begin
          send_tick(lv ^ (SW_N'(1) << $urandom_range(0, SW_N - 1)));
        end else begin
          send_tick(lv);
        end
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_access(1'b0, DEBOUNCE_ADDR, '0);
    set_debounce('0);
    for (int i = 0; i < 24; i++) begin
      tx_burst = ($urandom_range(0, 1) == 0);
      rx_burst <= ($urandom_range(0, 1) == 0);
      send_tick(opening_seq[i]);
    end
    wait_idle();

    set_debounce(CNT_MAX);
    send_tick('0);
    send_tick('0);
    send_tick('0);
    send_tick(ALL_RELEASED);
    wait_idle();

    set_debounce(16'd1);
    cfg_access(1'b1, UNMAPPED_ADDR, '0);
    run_phase(16'd1, 200);
    set_debounce(16'd3);
    run_phase(16'd3, 180);
    set_debounce(DEBOUNCE_RESET);
    run_phase(DEBOUNCE_RESET, 160);
    set_debounce('0);
    run_phase('0, 150);
    set_debounce(16'd7);
    run_phase(16'd7, 60);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("debounce_single_button_lock_tb: clean");
    end else begin
      $display("debounce_single_button_lock_tb: errors");
    end
    $finish;
  end

endmodule
